FILE: sv/knmh_pkg.sv
// ----------------------------------------------------------------------------
// knmh_pkg
// Shared types and constants for the bounded max-heap top-k block: request
// and response payloads, heap entry, sequencer states and operation codes.
// ----------------------------------------------------------------------------
package knmh_pkg;

   localparam int DIST_BITS      = 32;
   localparam int TAG_BITS       = 16;
   localparam int OP_BITS        = 2;
   localparam int K_BITS         = 5;
   localparam int COUNT_OUT_BITS = 5;

   localparam logic [K_BITS-1:0] K_RESET = 5'd16;

   localparam logic [OP_BITS-1:0] OP_OFFER   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READOUT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   typedef struct packed {
      logic [OP_BITS-1:0]   operation;
      logic [DIST_BITS-1:0] candidate_distance;
      logic [TAG_BITS-1:0]  candidate_tag;
   } req_type;

   typedef struct packed {
      logic                      result_kind;
      logic                      accepted;
      logic [DIST_BITS-1:0]      distance_out;
      logic [TAG_BITS-1:0]       tag_out;
      logic [COUNT_OUT_BITS-1:0] held_count;
      logic                      full_res;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic move;
      logic take_b;
   } sift_dec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RO_RD,
      ST_RO_EMIT,
      ST_DONE
   } state_type;

endpackage

FILE: sv/knmh_store.sv
// ----------------------------------------------------------------------------
// knmh_store
// Heap entry memory: one write port, two registered read ports, plus a
// shadow copy of the root slot kept current on every write to slot zero.
// ----------------------------------------------------------------------------
module knmh_store #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  knmh_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output knmh_pkg::entry_type rd_data_a,
   output knmh_pkg::entry_type rd_data_b,
   output knmh_pkg::entry_type root
);

   knmh_pkg::entry_type mem [CAPACITY];
   knmh_pkg::entry_type rd_a_ff;
   knmh_pkg::entry_type rd_b_ff;
   knmh_pkg::entry_type root_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
   assign root      = root_ff;

endmodule

FILE: sv/knmh_sift_cmp.sv
// ----------------------------------------------------------------------------
// knmh_sift_cmp
// Shared distance compare unit for both sift directions. Upward: move when
// the held item beats its parent. Downward: pick the larger child that beats
// the held item, left child first, ties keep the earlier choice.
// ----------------------------------------------------------------------------
module knmh_sift_cmp (
   input  logic                           up_mode,
   input  logic [knmh_pkg::DIST_BITS-1:0] item_dist,
   input  logic [knmh_pkg::DIST_BITS-1:0] a_dist,
   input  logic [knmh_pkg::DIST_BITS-1:0] b_dist,
   input  logic                           b_valid,
   output knmh_pkg::sift_dec_type         dec
);

   logic                           a_gt_item;
   logic [knmh_pkg::DIST_BITS-1:0] best_dist;
   logic                           b_gt_best;

   always_comb begin
      a_gt_item = a_dist > item_dist;
      best_dist = a_gt_item ? a_dist : item_dist;
      b_gt_best = b_valid && (b_dist > best_dist);
      if (up_mode) begin
         dec.move   = item_dist > a_dist;
         dec.take_b = 1'b0;
      end else begin
         dec.move   = a_gt_item || b_gt_best;
         dec.take_b = b_gt_best;
      end
   end

endmodule

FILE: sv/k_nearest_max_heap.sv
// ----------------------------------------------------------------------------
// k_nearest_max_heap
// Bounded max-heap keeping the k smallest offered distances with their tags.
// Offers append and sift up, or replace the root and sift down; readout
// streams held entries in slot order; clear empties the heap.
//
//   channel  ports                       handshake
//   request  start, busy, req_item       taken when start && !busy
//   result   rsp_strobe, rsp_item        one cycle per result, no stall
//   config   csr_write_en, csr_write_data  written when csr_write_en
//
// Offer: each heap level walked spends a read step (UP_RD or DN_RD) and a
//   compare-and-write step (UP_CMP or DN_CMP) on the shared compare unit,
//   then DONE emits the status. A rejected offer goes straight to DONE.
//   Readout reads and then emits each held entry in turn. Clear, unknown
//   codes and readout of an empty heap stay idle and emit no result. Reset
//   empties the heap and loads k_ff with 16; the memory needs no clearing
//   pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module k_nearest_max_heap #(
   parameter int CAPACITY = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  knmh_pkg::req_type               req_item,
   output logic                            rsp_strobe,
   output knmh_pkg::rsp_type               rsp_item,
   input  logic                            csr_write_en,
   input  logic [knmh_pkg::K_BITS-1:0]     csr_write_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;
   localparam int EW = (CW > knmh_pkg::K_BITS) ? CW : knmh_pkg::K_BITS;

   knmh_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [knmh_pkg::K_BITS-1:0] k_ff, k_in;
   knmh_pkg::entry_type     item_ff, item_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [AW-1:0]           par_ff, par_in;
   logic [AW-1:0]           lc_ff, lc_in;
   logic [AW-1:0]           rc_ff, rc_in;
   logic                    rcv_ff, rcv_in;
   logic                    take_ff, take_in;
   knmh_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   logic [EW-1:0]           k_wide;
   logic [CW-1:0]           eff_k;
   logic                    full;
   logic                    accept;
   logic [LW-1:0]           lc_w;
   logic [LW-1:0]           rc_w;
   logic                    up_mode;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   knmh_pkg::entry_type     wr_data;
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;
   knmh_pkg::entry_type     rd_data_a;
   knmh_pkg::entry_type     rd_data_b;
   knmh_pkg::entry_type     root;
   knmh_pkg::sift_dec_type  dec;

   knmh_store #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .root      (root)
   );

   knmh_sift_cmp u_cmp (
      .up_mode   (up_mode),
      .item_dist (item_ff.distance),
      .a_dist    (rd_data_a.distance),
      .b_dist    (rd_data_b.distance),
      .b_valid   (rcv_ff),
      .dec       (dec)
   );

   always_comb begin
      k_wide = EW'(k_ff);
      if (k_wide == '0) begin
         eff_k = CW'(1);
      end else if (k_wide > EW'(CAPACITY)) begin
         eff_k = CW'(CAPACITY);
      end else begin
         eff_k = CW'(k_wide);
      end
   end

   assign full    = count_ff >= eff_k;
   assign busy    = state_ff != knmh_pkg::ST_IDLE;
   assign accept  = start && !busy;
   assign lc_w    = LW'({pos_ff, 1'b1});
   assign rc_w    = LW'({pos_ff, 1'b0}) + LW'(2);
   assign up_mode = state_ff == knmh_pkg::ST_UP_CMP;
   assign k_in    = csr_write_en ? csr_write_data : k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= knmh_pkg::ST_IDLE;
         count_ff      <= '0;
         k_ff          <= knmh_pkg::K_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pos_ff  <= pos_in;
      par_ff  <= par_in;
      lc_ff   <= lc_in;
      rc_ff   <= rc_in;
      rcv_ff  <= rcv_in;
      take_ff <= take_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      item_in       = item_ff;
      pos_in        = pos_ff;
      par_in        = par_ff;
      lc_in         = lc_ff;
      rc_in         = rc_ff;
      rcv_in        = rcv_ff;
      take_in       = take_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = item_ff;
      rd_addr_a     = pos_ff;
      rd_addr_b     = pos_ff;

      unique case (state_ff)
         knmh_pkg::ST_IDLE: begin
            if (accept) begin
               item_in.distance = req_item.candidate_distance;
               item_in.tag      = req_item.candidate_tag;
               pos_in           = '0;
               if (req_item.operation == knmh_pkg::OP_OFFER) begin
                  if (!full) begin
                     pos_in   = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     take_in  = 1'b1;
                     state_in = knmh_pkg::ST_UP_RD;
                  end else if ((count_ff != '0) &&
                               (req_item.candidate_distance < root.distance)) begin
                     take_in  = 1'b1;
                     state_in = knmh_pkg::ST_DN_RD;
                  end else begin
                     take_in  = 1'b0;
                     state_in = knmh_pkg::ST_DONE;
                  end
               end else if (req_item.operation == knmh_pkg::OP_READOUT) begin
                  if (count_ff != '0) begin
                     state_in = knmh_pkg::ST_RO_RD;
                  end
               end else if (req_item.operation == knmh_pkg::OP_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         knmh_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = knmh_pkg::ST_DONE;
            end else begin
               par_in    = (pos_ff - AW'(1)) >> 1;
               rd_addr_a = (pos_ff - AW'(1)) >> 1;
               state_in  = knmh_pkg::ST_UP_CMP;
            end
         end
         knmh_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (dec.move) begin
               wr_data  = rd_data_a;
               pos_in   = par_ff;
               state_in = knmh_pkg::ST_UP_RD;
            end else begin
               state_in = knmh_pkg::ST_DONE;
            end
         end
         knmh_pkg::ST_DN_RD: begin
            if (lc_w >= LW'(count_ff)) begin
               wr_en    = 1'b1;
               state_in = knmh_pkg::ST_DONE;
            end else begin
               rcv_in    = rc_w < LW'(count_ff);
               lc_in     = lc_w[AW-1:0];
               rc_in     = (rc_w < LW'(count_ff)) ? rc_w[AW-1:0] : lc_w[AW-1:0];
               rd_addr_a = lc_w[AW-1:0];
               rd_addr_b = (rc_w < LW'(count_ff)) ? rc_w[AW-1:0] : lc_w[AW-1:0];
               state_in  = knmh_pkg::ST_DN_CMP;
            end
         end
         knmh_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (dec.move) begin
               wr_data  = dec.take_b ? rd_data_b : rd_data_a;
               pos_in   = dec.take_b ? rc_ff : lc_ff;
               state_in = knmh_pkg::ST_DN_RD;
            end else begin
               state_in = knmh_pkg::ST_DONE;
            end
         end
         knmh_pkg::ST_RO_RD: begin
            rd_addr_a = pos_ff;
            state_in  = knmh_pkg::ST_RO_EMIT;
         end
         knmh_pkg::ST_RO_EMIT: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.result_kind  = knmh_pkg::KIND_ENTRY;
            rsp_in.accepted     = 1'b0;
            rsp_in.distance_out = rd_data_a.distance;
            rsp_in.tag_out      = rd_data_a.tag;
            rsp_in.held_count   = knmh_pkg::COUNT_OUT_BITS'(count_ff);
            rsp_in.full_res     = full;
            rsp_in.last         = (CW'(pos_ff) + CW'(1)) == count_ff;
            pos_in              = pos_ff + AW'(1);
            if ((CW'(pos_ff) + CW'(1)) == count_ff) begin
               state_in = knmh_pkg::ST_IDLE;
            end else begin
               state_in = knmh_pkg::ST_RO_RD;
            end
         end
         knmh_pkg::ST_DONE: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.result_kind  = knmh_pkg::KIND_STATUS;
            rsp_in.accepted     = take_ff;
            rsp_in.distance_out = (count_ff != '0) ? root.distance : '0;
            rsp_in.tag_out      = (count_ff != '0) ? root.tag : '0;
            rsp_in.held_count   = knmh_pkg::COUNT_OUT_BITS'(count_ff);
            rsp_in.full_res     = full;
            rsp_in.last         = 1'b1;
            state_in            = knmh_pkg::ST_IDLE;
         end
         default: begin
            state_in = knmh_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_done_emits_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == knmh_pkg::ST_DONE) |=>
         (rsp_strobe && (rsp_item.result_kind == knmh_pkg::KIND_STATUS) && rsp_item.last))
      else $error("offer completion did not emit a status result");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.operation == knmh_pkg::OP_OFFER) && !full) |=>
         (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not grow the held count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(CAPACITY)))
      else $error("held count exceeds capacity");
`endif

endmodule
